[src/ansi_sgr_color_parser_unit_defines.svh]
// Assertion macros shared by the ANSI SGR color parser RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ANSI_SGR_COLOR_PARSER_UNIT_DEFINES_SVH
`define ANSI_SGR_COLOR_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ASP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asp: next-cycle check failed");

`endif

[src/asp_pkg.sv]
// Package of the ANSI SGR color parser: attribute and result types, byte and
// SGR code constants, and the 16-color and 256-color palette functions.
`default_nettype none

package asp_pkg;

    typedef struct packed {
        logic [23:0] fg;
        logic [23:0] bg;
        logic        bold;
    } attr_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [23:0] fg_color;
        logic [23:0] back_color;
        logic        bold;
    } res_t;

    // A result request from the parser to the output stage.
    typedef struct packed {
        logic valid;
        res_t res;
    } res_req_t;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'b1;

    localparam logic [23:0] DEFAULT_FG_RESET = 24'hFFFFFF;
    localparam logic [23:0] DEFAULT_BG_RESET = 24'h000000;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SGR    = 8'h6D;
    localparam logic [7:0] CH_CLEAR  = 8'h4A;

    localparam logic [11:0] ACC_MAX = 12'hFFF;

    localparam logic [11:0] SGR_RESET     = 12'd0;
    localparam logic [11:0] SGR_BOLD      = 12'd1;
    localparam logic [11:0] SGR_NORMAL    = 12'd22;
    localparam logic [11:0] SGR_FG_EXT    = 12'd38;
    localparam logic [11:0] SGR_BG_EXT    = 12'd48;
    localparam logic [11:0] SGR_MODE_PAL  = 12'd5;
    localparam logic [11:0] SGR_MODE_RGB  = 12'd2;
    localparam logic [11:0] SGR_FG_BASE   = 12'd30;
    localparam logic [11:0] SGR_BG_BASE   = 12'd40;
    localparam logic [11:0] SGR_FG_BRIGHT = 12'd90;
    localparam logic [11:0] SGR_BG_BRIGHT = 12'd100;

    function automatic logic [23:0] basic_color(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'hff0000;
            4'd2:    c = 24'h00ff00;
            4'd3:    c = 24'hffff00;
            4'd4:    c = 24'h0000ff;
            4'd5:    c = 24'hff00ff;
            4'd6:    c = 24'h00ffff;
            4'd7:    c = 24'hffffff;
            4'd8:    c = 24'h888888;
            4'd9:    c = 24'hff8888;
            4'd10:   c = 24'h88ff88;
            4'd11:   c = 24'hffff88;
            4'd12:   c = 24'h8888ff;
            4'd13:   c = 24'hff88ff;
            4'd14:   c = 24'h88ffff;
            default: c = 24'hffffff;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cube_step(input logic [2:0] idx);
        logic [7:0] s;
        case (idx)
            3'd0:    s = 8'd0;
            3'd1:    s = 8'd95;
            3'd2:    s = 8'd135;
            3'd3:    s = 8'd175;
            3'd4:    s = 8'd215;
            default: s = 8'd255;
        endcase
        return s;
    endfunction

    // 256-color palette entry for an index already saturated to 8 bits.
    function automatic logic [23:0] palette_color(input logic [7:0] n);
        logic [7:0]  i;
        logic [2:0]  r_idx;
        logic [2:0]  g_idx;
        logic [5:0]  rem36;
        logic [5:0]  rem6;
        logic [7:0]  gray;
        logic [23:0] c;
        i     = n - 8'd16;
        r_idx = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (i >= 8'(36 * k)) begin
                r_idx = 3'(k);
            end
        end
        rem36 = 6'(i - 8'(r_idx) * 8'd36);
        g_idx = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (rem36 >= 6'(6 * k)) begin
                g_idx = 3'(k);
            end
        end
        rem6 = rem36 - 6'(g_idx) * 6'd6;
        gray = 8'd8 + (n - 8'd232) * 8'd10;
        if (n < 8'd16) begin
            c = basic_color(n[3:0]);
        end else if (n <= 8'd231) begin
            c = {cube_step(r_idx), cube_step(g_idx), cube_step(rem6[2:0])};
        end else begin
            c = {gray, gray, gray};
        end
        return c;
    endfunction

    // Effect of one ordinary SGR code on the pending attributes.
    function automatic attr_t apply_code(input attr_t a, input logic [11:0] p,
                                         input logic [23:0] dfg,
                                         input logic [23:0] dbg);
        attr_t       r;
        logic [11:0] off;
        r   = a;
        off = 12'd0;
        if (p == SGR_RESET) begin
            r.fg   = dfg;
            r.bg   = dbg;
            r.bold = 1'b0;
        end else if (p == SGR_BOLD) begin
            r.bold = 1'b1;
        end else if (p == SGR_NORMAL) begin
            r.bold = 1'b0;
        end else if (p >= SGR_FG_BASE && p <= SGR_FG_BASE + 12'd7) begin
            off  = p - SGR_FG_BASE;
            r.fg = basic_color({1'b0, off[2:0]});
        end else if (p >= SGR_BG_BASE && p <= SGR_BG_BASE + 12'd7) begin
            off  = p - SGR_BG_BASE;
            r.bg = basic_color({1'b0, off[2:0]});
        end else if (p >= SGR_FG_BRIGHT && p <= SGR_FG_BRIGHT + 12'd7) begin
            off  = p - SGR_FG_BRIGHT;
            r.fg = basic_color({1'b1, off[2:0]});
        end else if (p >= SGR_BG_BRIGHT && p <= SGR_BG_BRIGHT + 12'd7) begin
            off  = p - SGR_BG_BRIGHT;
            r.bg = basic_color({1'b1, off[2:0]});
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/asp_if.sv]
// Handshake interfaces of the ANSI SGR color parser: byte input, result
// output and configuration write. Depends on nothing.
`default_nettype none

interface asp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface asp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [23:0] fg_color;
    logic [23:0] back_color;
    logic        bold;
    modport source (output valid, output kind, output char_code, output fg_color,
                    output back_color, output bold, input ready);
    modport sink (input valid, input kind, input char_code, input fg_color,
                  input back_color, input bold, output ready);
endinterface

interface asp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/asp_parser.sv]
// Escape/CSI parser state and single-pass byte update of the SGR attributes.
// Depends on asp_pkg and the assertion macros header.
`default_nettype none
`include "ansi_sgr_color_parser_unit_defines.svh"

module asp_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       in_byte,
    input  wire logic [23:0]      default_fg,
    input  wire logic [23:0]      default_bg,
    output asp_pkg::res_req_t     res
);
    import asp_pkg::*;

    typedef enum logic [1:0] {MODE_NORMAL, MODE_ESC, MODE_CSI} mode_t;
    typedef enum logic [2:0] {EXT_NONE, EXT_MODE, EXT_INDEX, EXT_RED, EXT_GREEN,
                              EXT_BLUE} ext_t;

    mode_t       mode_reg, mode_next;
    ext_t        ext_reg, ext_next;
    logic [11:0] acc_reg, acc_next;
    logic        tgt_fg_reg, tgt_fg_next;
    logic [15:0] rg_reg, rg_next;
    attr_t       pend_reg, pend_next;
    attr_t       comm_reg, comm_next;

    ext_t        ep_ext;
    logic        ep_tgt_fg;
    logic [15:0] ep_rg;
    attr_t       ep_pend;
    logic        ep_code;
    logic [7:0]  p_sat;
    logic [23:0] ext_color;
    logic        ext_set;
    logic [15:0] acc_prod;
    logic [11:0] acc_digit;
    logic [7:0]  digit;

    // Value of the accumulator after one more decimal digit, saturated.
    always_comb
    begin
        digit     = in_byte - CH_ZERO;
        acc_prod  = {4'b0, acc_reg} * 16'd10 + {12'b0, digit[3:0]};
        acc_digit = (acc_prod > {4'b0, ACC_MAX}) ? ACC_MAX : acc_prod[11:0];
    end

    // Effect of closing the current parameter.
    always_comb
    begin
        p_sat     = (acc_reg > 12'd255) ? 8'hFF : acc_reg[7:0];
        ep_ext    = EXT_NONE;
        ep_tgt_fg = tgt_fg_reg;
        ep_rg     = rg_reg;
        ep_pend   = pend_reg;
        ep_code   = 1'b0;
        ext_set   = 1'b0;
        ext_color = palette_color(p_sat);
        case (ext_reg)
            EXT_MODE:
            begin
                if (acc_reg == SGR_MODE_PAL) begin
                    ep_ext = EXT_INDEX;
                end else if (acc_reg == SGR_MODE_RGB) begin
                    ep_ext = EXT_RED;
                end else begin
                    ep_code = 1'b1;
                end
            end
            EXT_INDEX:
            begin
                ext_set = 1'b1;
            end
            EXT_RED:
            begin
                ep_rg  = {p_sat, 8'h00};
                ep_ext = EXT_GREEN;
            end
            EXT_GREEN:
            begin
                ep_rg  = {rg_reg[15:8], p_sat};
                ep_ext = EXT_BLUE;
            end
            EXT_BLUE:
            begin
                ext_color = {rg_reg, p_sat};
                ext_set   = 1'b1;
            end
            default:
            begin
                ep_code = 1'b1;
            end
        endcase
        if (ext_set) begin
            if (tgt_fg_reg) begin
                ep_pend.fg = ext_color;
            end else begin
                ep_pend.bg = ext_color;
            end
        end
        if (ep_code) begin
            if (acc_reg == SGR_FG_EXT || acc_reg == SGR_BG_EXT) begin
                ep_tgt_fg = (acc_reg == SGR_FG_EXT);
                ep_ext    = EXT_MODE;
            end else begin
                ep_pend = apply_code(pend_reg, acc_reg, default_fg, default_bg);
            end
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        ext_next    = ext_reg;
        acc_next    = acc_reg;
        tgt_fg_next = tgt_fg_reg;
        rg_next     = rg_reg;
        pend_next   = pend_reg;
        comm_next   = comm_reg;
        res.valid           = 1'b0;
        res.res.kind        = KIND_CHAR;
        res.res.char_code   = 8'h00;
        res.res.fg_color    = comm_reg.fg;
        res.res.back_color  = comm_reg.bg;
        res.res.bold        = comm_reg.bold;
        if (fire) begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (in_byte == CH_ESC) begin
                        mode_next = MODE_ESC;
                    end else if (in_byte == CH_LF) begin
                        res.valid    = 1'b1;
                        res.res.kind = KIND_NEWLINE;
                    end else begin
                        res.valid         = 1'b1;
                        res.res.char_code = in_byte;
                    end
                end
                MODE_ESC:
                begin
                    if (in_byte == CH_LBRACK) begin
                        mode_next = MODE_CSI;
                        acc_next  = 12'd0;
                        ext_next  = EXT_NONE;
                        pend_next = comm_reg;
                    end else begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_CSI:
                begin
                    if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
                        acc_next = acc_digit;
                    end else if (in_byte == CH_SEMI) begin
                        ext_next    = ep_ext;
                        tgt_fg_next = ep_tgt_fg;
                        rg_next     = ep_rg;
                        pend_next   = ep_pend;
                        acc_next    = 12'd0;
                    end else if (in_byte == CH_SGR) begin
                        tgt_fg_next = ep_tgt_fg;
                        rg_next     = ep_rg;
                        pend_next   = ep_pend;
                        comm_next   = ep_pend;
                        acc_next    = 12'd0;
                        ext_next    = EXT_NONE;
                        mode_next   = MODE_NORMAL;
                    end else if (in_byte == CH_CLEAR) begin
                        acc_next     = 12'd0;
                        ext_next     = EXT_NONE;
                        pend_next    = comm_reg;
                        mode_next    = MODE_NORMAL;
                        res.valid    = 1'b1;
                        res.res.kind = KIND_CLEAR;
                    end else if (in_byte inside {"K", "H", "f", "A", "B", "C", "D",
                                                 "h", "l", "r"}) begin
                        acc_next  = 12'd0;
                        ext_next  = EXT_NONE;
                        pend_next = comm_reg;
                        mode_next = MODE_NORMAL;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_NORMAL;
            ext_reg    <= EXT_NONE;
            acc_reg    <= 12'd0;
            tgt_fg_reg <= 1'b0;
            rg_reg     <= 16'd0;
            pend_reg   <= '{fg: DEFAULT_FG_RESET, bg: DEFAULT_BG_RESET, bold: 1'b0};
            comm_reg   <= '{fg: DEFAULT_FG_RESET, bg: DEFAULT_BG_RESET, bold: 1'b0};
        end else begin
            mode_reg   <= mode_next;
            ext_reg    <= ext_next;
            acc_reg    <= acc_next;
            tgt_fg_reg <= tgt_fg_next;
            rg_reg     <= rg_next;
            pend_reg   <= pend_next;
            comm_reg   <= comm_next;
        end
    end

    `ASP_ASSERT_SAME(a_ext_only_in_csi, ext_reg != EXT_NONE, mode_reg == MODE_CSI)
    `ASP_ASSERT_SAME(a_acc_only_in_csi, acc_reg != 12'd0, mode_reg == MODE_CSI)
    `ASP_ASSERT_SAME(a_clear_from_csi, res.valid && res.res.kind == KIND_CLEAR, mode_reg == MODE_CSI && in_byte == CH_CLEAR)
    `ASP_ASSERT_NEXT(a_commit_on_sgr, !(fire && mode_reg == MODE_CSI && in_byte == CH_SGR), $stable(comm_reg))
    `ASP_ASSERT_SAME(a_no_result_idle, !fire, !res.valid)

endmodule

`default_nettype wire

[src/asp_out_stage.sv]
// Output register of the ANSI SGR color parser: holds one result request
// until the receiver takes it. Depends on asp_pkg and asp_if.
`default_nettype none

module asp_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire asp_pkg::res_req_t req,
    output logic                   free,
    asp_result_if.source           out_ch
);
    import asp_pkg::*;

    logic vld_reg;
    res_t res_reg;

    // The register can load when it is empty or being emptied this cycle.
    assign free = !vld_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (free) begin
            vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && req.valid) begin
            res_reg <= req.res;
        end
    end

    assign out_ch.valid      = vld_reg;
    assign out_ch.kind       = res_reg.kind;
    assign out_ch.char_code  = res_reg.char_code;
    assign out_ch.fg_color   = res_reg.fg_color;
    assign out_ch.back_color = res_reg.back_color;
    assign out_ch.bold       = res_reg.bold;

endmodule

`default_nettype wire

[src/ansi_sgr_color_parser_unit.sv]
// ANSI SGR color parser, top level: the input byte register, default color
// registers, the parser and the output stage. Uses asp_pkg, asp_if and
// the modules asp_parser and asp_out_stage.
//
// Usage: terminal bytes enter on in_ch, one per request. Character bytes,
// newlines and clear-screen events leave on out_ch with the committed
// foreground, background and bold; other escape sequences produce no result.
// cfg_ch writes default_fg (index 0) and default_bg (index 1); it is always
// ready and is meant to be written only while the block is idle.
// A byte that is accepted waits in the input register and then passes through
// the parser into the output register. Throughput is one byte per cycle while
// the receiver takes results; the parser updates the attributes in one pass.
// Reset puts the parser in normal mode with both attribute sets at the reset
// defaults (white on black, not bold) and empties both registers.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more byte before in_ch.ready drops.
`default_nettype none

module ansi_sgr_color_parser_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    asp_byte_if.sink      in_ch,
    asp_result_if.source  out_ch,
    asp_cfg_if.sink       cfg_ch
);
    import asp_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic [23:0] dfg_reg;
    logic [23:0] dbg_reg;
    logic        out_free;
    logic        fire;
    res_req_t    req;

    assign fire         = in_vld_reg && out_free;
    assign in_ch.ready  = !in_vld_reg || fire;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
            dfg_reg    <= DEFAULT_FG_RESET;
            dbg_reg    <= DEFAULT_BG_RESET;
        end else begin
            if (in_ch.ready) begin
                in_vld_reg <= in_ch.valid;
            end
            if (cfg_ch.valid && cfg_ch.index == CFG_DEFAULT_FG) begin
                dfg_reg <= cfg_ch.data;
            end
            if (cfg_ch.valid && cfg_ch.index == CFG_DEFAULT_BG) begin
                dbg_reg <= cfg_ch.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid) begin
            in_byte_reg <= in_ch.in_byte;
        end
    end

    asp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .in_byte    (in_byte_reg),
        .default_fg (dfg_reg),
        .default_bg (dbg_reg),
        .res        (req)
    );

    asp_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

[verif/tb_ansi_sgr_color_parser_unit.sv]
// Self-checking testbench for ansi_sgr_color_parser_unit: streams terminal bytes through the
// parser and checks every result against a built-in model of the SGR attribute tracking.
// Depends on asp_pkg, the handshake interfaces in asp_if and the RTL of the unit.
`default_nettype none

module tb_ansi_sgr_color_parser_unit;
    import asp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 150;

    typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_CSI} parse_mode_e;
    typedef enum logic [2:0] {
        EXT_NONE, EXT_MODE, EXT_INDEX, EXT_RED, EXT_GREEN, EXT_BLUE
    } ext_stage_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    asp_byte_if   in_ch();
    asp_result_if out_ch();
    asp_cfg_if    cfg_ch();

    ansi_sgr_color_parser_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg_ch(cfg_ch)
    );

    logic [23:0] colors16 [16] = '{
        24'h000000, 24'hff0000, 24'h00ff00, 24'hffff00,
        24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff,
        24'h888888, 24'hff8888, 24'h88ff88, 24'hffff88,
        24'h8888ff, 24'hff88ff, 24'h88ffff, 24'hffffff
    };
    logic [7:0] cube_levels [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
    string abort_finals = "KHfABCDhlr";

    // Model state and its copy of the default color registers.
    logic [23:0]  shadow_fg = DEFAULT_FG_RESET;
    logic [23:0]  shadow_bg = DEFAULT_BG_RESET;
    parse_mode_e  pmode = PM_NORMAL;
    logic [11:0]  acc_param = '0;
    ext_stage_e   ext = EXT_NONE;
    bit           ext_fg = 1'b0;
    logic [15:0]  red_green = '0;
    attr_t        pend = '{fg: DEFAULT_FG_RESET, bg: DEFAULT_BG_RESET, bold: 1'b0};
    attr_t        comm = '{fg: DEFAULT_FG_RESET, bg: DEFAULT_BG_RESET, bold: 1'b0};

    logic [7:0]   tx_bytes [$];
    res_t         styled_results [$];
    res_t         oldest;
    res_t         fresh;

    int unsigned  pushed_cnt = 0;
    int unsigned  accepted_cnt = 0;
    int unsigned  err_cnt = 0;
    int unsigned  n_chars = 0;
    int unsigned  n_newlines = 0;
    int unsigned  n_clears = 0;
    int unsigned  n_settings = 0;
    int unsigned  tx_gap = 0;
    int unsigned  rx_stall = 0;
    bit           in_fire = 1'b0;
    bit           gaps_on = 1'b0;
    bit           rx_hold = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] sat8(input int unsigned v);
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [23:0] palette_rgb(input logic [7:0] n);
        int unsigned i;
        logic [7:0]  g;
        if (n < 8'd16)
        begin
            return colors16[n[3:0]];
        end
        if (n <= 8'd231)
        begin
            i = n - 16;
            return {cube_levels[i / 36], cube_levels[(i % 36) / 6], cube_levels[i % 6]};
        end
        g = 8'd8 + (n - 8'd232) * 8'd10;
        return {g, g, g};
    endfunction

    function automatic void set_extended(input logic [23:0] rgb);
        if (ext_fg)
        begin
            pend.fg = rgb;
        end
        else
        begin
            pend.bg = rgb;
        end
    endfunction

    function automatic void sgr_apply(input logic [11:0] p);
        if (p == SGR_FG_EXT || p == SGR_BG_EXT)
        begin
            ext_fg = (p == SGR_FG_EXT);
            ext = EXT_MODE;
        end
        else if (p == SGR_RESET)
        begin
            pend.fg = shadow_fg;
            pend.bg = shadow_bg;
            pend.bold = 1'b0;
        end
        else if (p == SGR_BOLD)
        begin
            pend.bold = 1'b1;
        end
        else if (p == SGR_NORMAL)
        begin
            pend.bold = 1'b0;
        end
        else if (p >= SGR_FG_BASE && p < SGR_FG_BASE + 8)
        begin
            pend.fg = colors16[p - SGR_FG_BASE];
        end
        else if (p >= SGR_BG_BASE && p < SGR_BG_BASE + 8)
        begin
            pend.bg = colors16[p - SGR_BG_BASE];
        end
        else if (p >= SGR_FG_BRIGHT && p < SGR_FG_BRIGHT + 8)
        begin
            pend.fg = colors16[p - SGR_FG_BRIGHT + 8];
        end
        else if (p >= SGR_BG_BRIGHT && p < SGR_BG_BRIGHT + 8)
        begin
            pend.bg = colors16[p - SGR_BG_BRIGHT + 8];
        end
    endfunction

    function automatic void finish_param(input logic [11:0] p);
        case (ext)
            EXT_MODE:
            begin
                if (p == SGR_MODE_PAL)
                begin
                    ext = EXT_INDEX;
                end
                else if (p == SGR_MODE_RGB)
                begin
                    ext = EXT_RED;
                end
                else
                begin
                    ext = EXT_NONE;
                    sgr_apply(p);
                end
            end
            EXT_INDEX:
            begin
                set_extended(palette_rgb(sat8(p)));
                ext = EXT_NONE;
            end
            EXT_RED:
            begin
                red_green = {sat8(p), 8'h00};
                ext = EXT_GREEN;
            end
            EXT_GREEN:
            begin
                red_green[7:0] = sat8(p);
                ext = EXT_BLUE;
            end
            EXT_BLUE:
            begin
                set_extended({red_green, sat8(p)});
                ext = EXT_NONE;
            end
            default:
            begin
                ext = EXT_NONE;
                sgr_apply(p);
            end
        endcase
    endfunction

    function automatic bit is_abort_final(input logic [7:0] b);
        for (int k = 0; k < abort_finals.len(); k++)
        begin
            if (b == abort_finals[k])
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic res_t with_attrs(input logic [1:0] kind, input logic [7:0] ch);
        res_t r;
        r.kind = kind;
        r.char_code = ch;
        r.fg_color = comm.fg;
        r.back_color = comm.bg;
        r.bold = comm.bold;
        return r;
    endfunction

    function automatic void abandon_sequence();
        acc_param = '0;
        ext = EXT_NONE;
        pend = comm;
        pmode = PM_NORMAL;
    endfunction

    // Advances the parser model by one byte; returns 1 when the byte yields a result.
    function automatic bit sgr_parse_byte(input logic [7:0] b, output res_t r);
        int unsigned acc;
        r = '0;
        case (pmode)
            PM_NORMAL:
            begin
                if (b == CH_ESC)
                begin
                    pmode = PM_ESC;
                    return 1'b0;
                end
                r = (b == CH_LF) ? with_attrs(KIND_NEWLINE, 8'h00) : with_attrs(KIND_CHAR, b);
                return 1'b1;
            end
            PM_ESC:
            begin
                if (b == CH_LBRACK)
                begin
                    pmode = PM_CSI;
                    acc_param = '0;
                    ext = EXT_NONE;
                    pend = comm;
                end
                else
                begin
                    pmode = PM_NORMAL;
                end
                return 1'b0;
            end
            default:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    acc = 32'(acc_param) * 10 + 32'(b - CH_ZERO);
                    acc_param = (acc > ACC_MAX) ? ACC_MAX : acc[11:0];
                end
                else if (b == CH_SEMI)
                begin
                    finish_param(acc_param);
                    acc_param = '0;
                end
                else if (b == CH_SGR)
                begin
                    finish_param(acc_param);
                    acc_param = '0;
                    ext = EXT_NONE;
                    comm = pend;
                    pmode = PM_NORMAL;
                end
                else if (b == CH_CLEAR)
                begin
                    abandon_sequence();
                    r = with_attrs(KIND_CLEAR, 8'h00);
                    return 1'b1;
                end
                else if (is_abort_final(b))
                begin
                    abandon_sequence();
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (styled_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d char %h",
                         $time, out_ch.kind, out_ch.char_code);
                err_cnt++;
            end
            else
            begin
                oldest = styled_results.pop_front();
                check_field("kind", 24'(oldest.kind), 24'(out_ch.kind));
                check_field("char_code", 24'(oldest.char_code), 24'(out_ch.char_code));
                check_field("fg_color", oldest.fg_color, out_ch.fg_color);
                check_field("back_color", oldest.back_color, out_ch.back_color);
                check_field("bold", 24'(oldest.bold), 24'(out_ch.bold));
                case (oldest.kind)
                    KIND_CHAR:    n_chars++;
                    KIND_NEWLINE: n_newlines++;
                    default:      n_clears++;
                endcase
            end
        end
        if (in_fire)
        begin
            accepted_cnt++;
            if (sgr_parse_byte(in_ch.in_byte, fresh))
            begin
                styled_results.insert(styled_results.size(), fresh);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_fire)
        begin
            if (tx_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                tx_gap--;
            end
            else if (tx_bytes.size() != 0)
            begin
                in_ch.in_byte <= tx_bytes.pop_front();
                in_ch.valid <= 1'b1;
                tx_gap = pick_gap();
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (rx_stall != 0)
        begin
            out_ch.ready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
        pushed_cnt++;
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            queue_byte(s[k]);
        end
    endtask

    task automatic queue_csi_start();
        queue_byte(CH_ESC);
        queue_byte(CH_LBRACK);
    endtask

    task automatic queue_printables(input int unsigned n);
        logic [7:0] b;
        repeat (n)
        begin
            b = ($urandom_range(9) == 0) ? CH_LF : 8'($urandom_range(255));
            if (b == CH_ESC)
            begin
                b = 8'h7E;
            end
            queue_byte(b);
        end
    endtask

    function automatic int unsigned color_value();
        return ($urandom_range(99) < 85) ? $urandom_range(255) : $urandom_range(256, 9999);
    endfunction

    // One parameter group; an extended color spans several numbers.
    function automatic string sgr_param();
        int unsigned r;
        int unsigned head;
        r = $urandom_range(99);
        head = $urandom_range(1) ? SGR_FG_EXT : SGR_BG_EXT;
        if (r < 8)
        begin
            return "";
        end
        if (r < 18)
        begin
            case ($urandom_range(2))
                0:       return $sformatf("%0d", SGR_RESET);
                1:       return $sformatf("%0d", SGR_BOLD);
                default: return $sformatf("%0d", SGR_NORMAL);
            endcase
        end
        if (r < 40)
        begin
            case ($urandom_range(3))
                0:       return $sformatf("%0d", SGR_FG_BASE + $urandom_range(7));
                1:       return $sformatf("%0d", SGR_BG_BASE + $urandom_range(7));
                2:       return $sformatf("%0d", SGR_FG_BRIGHT + $urandom_range(7));
                default: return $sformatf("%0d", SGR_BG_BRIGHT + $urandom_range(7));
            endcase
        end
        if (r < 55)
        begin
            return $sformatf("%0d;%0d;%0d", head, SGR_MODE_PAL, color_value());
        end
        if (r < 70)
        begin
            return $sformatf("%0d;%0d;%0d;%0d;%0d", head, SGR_MODE_RGB,
                             color_value(), color_value(), color_value());
        end
        if (r < 75)
        begin
            return $sformatf("%0d;%0d", head, $urandom_range(1) ? $urandom_range(9) :
                             ($urandom_range(1) ? SGR_FG_EXT : SGR_BG_EXT));
        end
        if (r < 80)
        begin
            return $urandom_range(1) ? $sformatf("%0d;%0d;%0d", head, SGR_MODE_RGB,
                                                 color_value())
                                     : $sformatf("%0d;%0d", head, SGR_MODE_PAL);
        end
        if (r < 90)
        begin
            return $sformatf("%0d", $urandom_range(110));
        end
        if (r < 95)
        begin
            return $sformatf("%0d", $urandom_range(4000, 99999));
        end
        return $sformatf("000%0d", $urandom_range(255));
    endfunction

    task automatic queue_sgr_sequence();
        int unsigned n;
        int unsigned r;
        n = $urandom_range(4);
        queue_csi_start();
        for (int k = 0; k < n; k++)
        begin
            if (k > 0)
            begin
                queue_byte(CH_SEMI);
            end
            queue_text(sgr_param());
            if ($urandom_range(19) == 0)
            begin
                case ($urandom_range(3))
                    0:       queue_byte(CH_LF);
                    1:       queue_byte(CH_ESC);
                    2:       queue_byte(8'h20);
                    default: queue_byte(8'hC3);
                endcase
            end
        end
        r = $urandom_range(99);
        if (r < 80)
        begin
            queue_byte(CH_SGR);
        end
        else if (r < 88)
        begin
            queue_byte(CH_CLEAR);
        end
        else if (r < 96)
        begin
            queue_byte(abort_finals[$urandom_range(abort_finals.len() - 1)]);
        end
        queue_printables($urandom_range(1, 2));
    endtask

    task automatic queue_noise();
        case ($urandom_range(3))
            0:
            begin
                queue_byte(CH_ESC);
                queue_byte(8'($urandom_range(255)));
            end
            1:
            begin
                queue_csi_start();
                repeat ($urandom_range(1, 6))
                begin
                    queue_byte(8'($urandom_range(255)));
                end
            end
            2:
            begin
                queue_byte(CH_ESC);
                queue_byte(CH_ESC);
                queue_printables(1);
            end
            default:
            begin
                queue_csi_start();
                queue_text(sgr_param());
                queue_byte($urandom_range(1) ? CH_CLEAR :
                           abort_finals[$urandom_range(abort_finals.len() - 1)]);
            end
        endcase
        queue_printables(1);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned stop_at;
        int unsigned r;
        stop_at = pushed_cnt + count;
        while (pushed_cnt < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                queue_printables($urandom_range(1, 4));
            end
            else if (r < 85)
            begin
                queue_sgr_sequence();
            end
            else
            begin
                queue_noise();
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || styled_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_DEFAULT_FG)
        begin
            shadow_fg = val;
        end
        else
        begin
            shadow_bg = val;
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [23:0] fg;
        logic [23:0] bg;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gaps_on = 1'b1;
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_LF);
        queue_byte(CH_ESC);
        queue_text("xy");
        queue_csi_start();
        queue_text("1");
        queue_byte(CH_SGR);
        queue_text("b");
        queue_csi_start();
        queue_text("97");
        queue_byte(CH_CLEAR);
        queue_csi_start();
        queue_byte(CH_SEMI);
        queue_text("45H");
        queue_text("c");
        queue_csi_start();
        queue_byte(CH_SGR);
        queue_text("d");

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    fg = 24'h000000;
                    bg = 24'hFFFFFF;
                end
                2:
                begin
                    fg = 24'hFFFFFF;
                    bg = 24'h000000;
                end
                default:
                begin
                    fg = 24'($urandom);
                    bg = 24'($urandom);
                end
            endcase
            wait_idle();
            write_reg(CFG_DEFAULT_FG, fg);
            write_reg(CFG_DEFAULT_BG, bg);
            n_settings++;
            gaps_on = (ph != 1) && (ph != 4);
            queue_random(140);
            if (ph == 1)
            begin
                // The sender keeps going while the receiver is held off, so the
                // unit fills up and has to back-pressure its input.
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
        end
        wait_idle();

        $display("Streamed %0d bytes under %0d default color settings plus the reset ones.",
                 accepted_cnt, n_settings);
        $display("Checked %0d characters, %0d newlines and %0d clear events.",
                 n_chars, n_newlines, n_clears);
        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/asp_pkg.sv
src/asp_if.sv
src/asp_parser.sv
src/asp_out_stage.sv
src/ansi_sgr_color_parser_unit.sv
verif/tb_ansi_sgr_color_parser_unit.sv
